// ----- design/gsfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gsfd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned WORD_W     = 16;
    localparam int unsigned TEMP_W     = 18;
    localparam int unsigned HUM_W      = 17;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 56;
    localparam int unsigned OUT_USER_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd1;

    localparam logic [BYTE_W-1:0] CRC_POLY_RESET = 8'h31;
    localparam logic [BYTE_W-1:0] CRC_INIT_RESET = 8'hFF;

    // scaling constants; fractional shift is 13 bits
    localparam logic [14:0] TEMP_SCALE  = 15'd21875;
    localparam logic [13:0] HUM_SCALE   = 14'd12500;
    localparam logic [17:0] TEMP_OFFSET = 18'd45000;
    localparam int unsigned FRAC_SHIFT  = 13;

    // byte slot inside one word, and word index inside one frame
    localparam logic [1:0] SLOT_HIGH  = 2'd0;
    localparam logic [1:0] SLOT_LOW   = 2'd1;
    localparam logic [1:0] SLOT_CHECK = 2'd2;
    localparam logic [1:0] WORD_CO2   = 2'd0;
    localparam logic [1:0] WORD_TEMP  = 2'd1;
    localparam logic [1:0] WORD_HUM   = 2'd2;

    typedef struct packed {
        logic [WORD_W-1:0] co2_word;
        logic [WORD_W-1:0] temperature_word;
        logic [WORD_W-1:0] humidity_word;
        logic              check_failed;
        logic [1:0]        first_failed_index;
    } frame_t;

    // CRC-8, MSB first, eight unrolled shift steps
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data,
                                                    input logic [BYTE_W-1:0] poly);
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ poly;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/gas_sensor_frame_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Measurement frame decoder. Feed the nine frame bytes in order, one word per
// byte (tdata = the byte, tuser = frame start flag): three sensor words, each
// two big-endian data bytes followed by a CRC-8 check byte computed MSB first
// with the programmed polynomial and start value. A flagged byte always opens
// a new frame and drops any partial one; without a flag the byte after a
// finished frame (or after reset) is byte one anyway. One result word leaves
// per frame: raw CO2, temperature in milli-degrees C and humidity in
// milli-percent, or all-zero measurements with status set and the index of
// the first failing word. The decoder takes one byte per cycle while the
// result side keeps up; the byte path runs input register -> CRC/frame state
// -> frame register -> scaling multipliers -> output register before a result
// shows on m_tvalid. Backpressure on the result side stalls the byte side only
// once the frame and output registers are both full. Register writes (index 0
// polynomial, index 1 start value) are always accepted; the polynomial applies
// from the next byte, the start value from the next word.
module gas_sensor_frame_decoder_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // byte stream in
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [gsfd_pkg::IN_DATA_W-1:0] s_tdata,   // [7:0] byte_value
    input  wire logic                          s_tuser,   // [0] frame_start
    // result stream out
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [gsfd_pkg::OUT_DATA_W-1:0]    m_tdata,   // [15:0] co2_ticks,
                                                          // [33:16] temperature_milli_c,
                                                          // [50:34] humidity_milli_pct
    output logic [gsfd_pkg::OUT_USER_W-1:0]    m_tuser,   // [0] status, [2:1] failing_word
    // register writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gsfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gsfd_pkg::BYTE_W-1:0]    cfg_data
);
    import gsfd_pkg::*;

    logic [BYTE_W-1:0] crc_poly_reg, crc_poly_next;
    logic [BYTE_W-1:0] crc_init_reg, crc_init_next;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;
    logic              core_ready;
    logic              fr_valid;
    frame_t            fr_data;
    logic              fr_take;
    logic              s_fire;

    // register file: writes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        crc_poly_next = crc_poly_reg;
        crc_init_next = crc_init_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_CRC_POLY: crc_poly_next = cfg_data;
                REG_CRC_INIT: crc_init_next = cfg_data;
                default: ;
            endcase
        end
    end

    // input register: hold the byte until the core takes it
    assign s_tready = !in_valid_reg || core_ready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg && !core_ready;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_poly_reg <= CRC_POLY_RESET;
            crc_init_reg <= CRC_INIT_RESET;
            in_valid_reg <= 1'b0;
        end else begin
            crc_poly_reg <= crc_poly_next;
            crc_init_reg <= crc_init_next;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg  <= s_tdata[BYTE_W-1:0];
            in_start_reg <= s_tuser;
        end
    end

    gsfd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .crc_poly (crc_poly_reg),
        .crc_init (crc_init_reg),
        .in_valid (in_valid_reg),
        .in_byte  (in_byte_reg),
        .in_start (in_start_reg),
        .in_ready (core_ready),
        .fr_valid (fr_valid),
        .fr_data  (fr_data),
        .fr_take  (fr_take)
    );

    gsfd_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fr_valid (fr_valid),
        .fr_data  (fr_data),
        .fr_take  (fr_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a failed frame carries no measurements
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("failed frame with nonzero measurements");

    // a passing frame reports word index zero
    a_pass_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tuser[2:1] == 2'd0)
        else $error("passing frame with failing word index");

    // only three words per frame
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[2:1] != 2'd3)
        else $error("failing word index out of range");

    // a frame record waiting while the output is free must move on
    a_frame_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        fr_valid && !m_tvalid |=> m_tvalid)
        else $error("frame record not forwarded");

endmodule

`default_nettype wire

// ----- design/gsfd_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsfd_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [gsfd_pkg::BYTE_W-1:0] crc_poly,
    input  wire logic [gsfd_pkg::BYTE_W-1:0] crc_init,
    input  wire logic                       in_valid,
    input  wire logic [gsfd_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                       in_start,
    output logic                            in_ready,
    output logic                            fr_valid,
    output gsfd_pkg::frame_t                fr_data,
    input  wire logic                       fr_take
);
    import gsfd_pkg::*;

    logic [1:0]        slot_reg,  slot_next;
    logic [1:0]        word_reg,  word_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic              failed_reg, failed_next;
    logic [1:0]        fidx_reg,  fidx_next;
    logic [BYTE_W-1:0] hold_reg;
    logic [WORD_W-1:0] co2_reg, temp_reg, hum_reg;
    logic              fr_valid_reg, fr_valid_next;
    frame_t            fr_data_reg;

    logic              fire, last;
    logic [1:0]        slot_cur, word_cur;
    logic [BYTE_W-1:0] check_cur, check_upd;
    logic              failed_cur, mismatch;
    logic [1:0]        fidx_cur;

    assign in_ready = !fr_valid_reg || fr_take;
    assign fire     = in_valid && in_ready;

    // frame start drops any partial frame
    always_comb begin
        slot_cur   = in_start ? SLOT_HIGH : slot_reg;
        word_cur   = in_start ? WORD_CO2  : word_reg;
        check_cur  = in_start ? crc_init  : check_reg;
        failed_cur = in_start ? 1'b0      : failed_reg;
        fidx_cur   = in_start ? 2'd0      : fidx_reg;
        check_upd  = crc8_byte(check_cur, in_byte, crc_poly);
        mismatch   = (slot_cur == SLOT_CHECK) && (check_cur != in_byte) && !failed_cur;
        last       = (slot_cur == SLOT_CHECK) && (word_cur == WORD_HUM);
    end

    always_comb begin
        slot_next   = slot_reg;
        word_next   = word_reg;
        check_next  = check_reg;
        failed_next = failed_reg;
        fidx_next   = fidx_reg;
        if (fire) begin
            failed_next = failed_cur || mismatch;
            fidx_next   = mismatch ? word_cur : fidx_cur;
            if (slot_cur == SLOT_CHECK) begin
                check_next = crc_init;
                slot_next  = SLOT_HIGH;
                word_next  = last ? WORD_CO2 : word_cur + 2'd1;
                if (last) begin
                    failed_next = 1'b0;
                    fidx_next   = 2'd0;
                end
            end else begin
                check_next = check_upd;
                slot_next  = slot_cur + 2'd1;
                word_next  = word_cur;
            end
        end
    end

    always_comb begin
        fr_valid_next = fr_valid_reg && !fr_take;
        if (fire && last) begin
            fr_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= SLOT_HIGH;
            word_reg     <= WORD_CO2;
            check_reg    <= CRC_INIT_RESET;
            failed_reg   <= 1'b0;
            fidx_reg     <= 2'd0;
            fr_valid_reg <= 1'b0;
        end else begin
            slot_reg     <= slot_next;
            word_reg     <= word_next;
            check_reg    <= check_next;
            failed_reg   <= failed_next;
            fidx_reg     <= fidx_next;
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && slot_cur == SLOT_HIGH) begin
            hold_reg <= in_byte;
        end
        if (fire && slot_cur == SLOT_LOW) begin
            case (word_cur)
                WORD_CO2:  co2_reg  <= {hold_reg, in_byte};
                WORD_TEMP: temp_reg <= {hold_reg, in_byte};
                default:   hum_reg  <= {hold_reg, in_byte};
            endcase
        end
        if (fire && last) begin
            fr_data_reg.co2_word           <= co2_reg;
            fr_data_reg.temperature_word   <= temp_reg;
            fr_data_reg.humidity_word      <= hum_reg;
            fr_data_reg.check_failed       <= failed_cur || mismatch;
            fr_data_reg.first_failed_index <= mismatch ? word_cur : fidx_cur;
        end
    end

    assign fr_valid = fr_valid_reg;
    assign fr_data  = fr_data_reg;

endmodule

`default_nettype wire

// ----- design/gsfd_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsfd_scale (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fr_valid,
    input  wire gsfd_pkg::frame_t              fr_data,
    output logic                               fr_take,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [gsfd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [gsfd_pkg::OUT_USER_W-1:0]    m_tuser
);
    import gsfd_pkg::*;

    logic                     valid_reg, valid_next;
    logic [OUT_DATA_W-1:0]    data_reg;
    logic [OUT_USER_W-1:0]    user_reg;
    logic [30:0]              t_prod;
    logic [29:0]              h_prod;
    logic signed [TEMP_W-1:0] temp_val;
    logic [HUM_W-1:0]         hum_val;
    logic [OUT_DATA_W-1:0]    data_next;
    logic                     load;

    assign fr_take = !valid_reg || m_tready;
    assign load    = fr_valid && fr_take;

    always_comb begin
        t_prod   = 31'(fr_data.temperature_word) * 31'(TEMP_SCALE);
        h_prod   = 30'(fr_data.humidity_word) * 30'(HUM_SCALE);
        temp_val = $signed(t_prod[30:FRAC_SHIFT] - TEMP_OFFSET);
        hum_val  = h_prod[29:FRAC_SHIFT];
        if (fr_data.check_failed) begin
            data_next = '0;
        end else begin
            data_next = {5'd0, hum_val, temp_val, fr_data.co2_word};
        end
    end

    always_comb begin
        valid_next = valid_reg && !m_tready;
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
            user_reg <= {fr_data.check_failed ? fr_data.first_failed_index : 2'd0,
                         fr_data.check_failed};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

// ----- dv/gas_sensor_frame_decoder_top_test.sv -----
`timescale 1ns / 1ps

module gas_sensor_frame_decoder_top_test;
    import gsfd_pkg::*;

    localparam int unsigned LAST_POS = 8;
    // register indexes that decode to nothing in the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 9;
    localparam int BYTES_PER_PHASE = 150;
    localparam int BUSY_PCT        = 21;
    localparam int QUIET_PHASE     = 3;

    typedef struct {
        logic [WORD_W-1:0] co2;
        logic [TEMP_W-1:0] temp;
        logic [HUM_W-1:0]  hum;
        logic              status;
        logic [1:0]        failing;
    } reading_t;

    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] value;
    } frame_byte_t;

    // Tracks the frame decoder byte by byte and holds the readings it owes.
    class reading_scoreboard;
        logic [BYTE_W-1:0] poly;
        logic [BYTE_W-1:0] init;
        logic [3:0]        pos;
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] high_hold;
        logic [WORD_W-1:0] co2_w;
        logic [WORD_W-1:0] temp_w;
        logic [WORD_W-1:0] hum_w;
        logic              failed;
        logic [1:0]        failed_idx;
        reading_t          readings_due[$];
        int                errors;

        function new();
            poly   = CRC_POLY_RESET;
            init   = CRC_INIT_RESET;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            pos        = '0;
            crc        = init;
            high_hold  = '0;
            co2_w      = '0;
            temp_w     = '0;
            hum_w      = '0;
            failed     = 1'b0;
            failed_idx = '0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
            if (idx == REG_CRC_POLY) begin
                poly = val;
            end else if (idx == REG_CRC_INIT) begin
                init = val;
            end
        endfunction

        function logic [BYTE_W-1:0] crc_next(logic [BYTE_W-1:0] c, logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] r;
            r = c ^ b;
            repeat (BYTE_W) begin
                r = r[BYTE_W-1] ? ({r[BYTE_W-2:0], 1'b0} ^ poly) : {r[BYTE_W-2:0], 1'b0};
            end
            return r;
        endfunction

        function void take_byte(logic [BYTE_W-1:0] b, logic st);
            logic [1:0]        slot;
            logic [1:0]        word;
            logic [WORD_W-1:0] w;
            logic [31:0]       t_scaled;
            logic [31:0]       h_scaled;
            reading_t          r;
            if (st || pos > LAST_POS) begin
                clear_frame();
            end
            slot = 2'(pos % 3);
            word = 2'(pos / 3);
            w    = {high_hold, b};
            case (slot)
                SLOT_HIGH: begin
                    high_hold = b;
                    crc = crc_next(crc, b);
                end
                SLOT_LOW: begin
                    if (word == WORD_CO2) begin
                        co2_w = w;
                    end else if (word == WORD_TEMP) begin
                        temp_w = w;
                    end else begin
                        hum_w = w;
                    end
                    crc = crc_next(crc, b);
                end
                default: begin
                    if (crc != b && !failed) begin
                        failed     = 1'b1;
                        failed_idx = word;
                    end
                    crc = init;
                end
            endcase
            if (pos < LAST_POS) begin
                pos = pos + 1'b1;
                return;
            end
            pos = '0;
            if (failed) begin
                r.co2     = '0;
                r.temp    = '0;
                r.hum     = '0;
                r.status  = 1'b1;
                r.failing = failed_idx;
            end else begin
                t_scaled  = (32'(TEMP_SCALE) * 32'(temp_w)) >> FRAC_SHIFT;
                h_scaled  = (32'(HUM_SCALE) * 32'(hum_w)) >> FRAC_SHIFT;
                r.co2     = co2_w;
                r.temp    = TEMP_W'(t_scaled - 32'(TEMP_OFFSET));
                r.hum     = HUM_W'(h_scaled);
                r.status  = 1'b0;
                r.failing = '0;
            end
            readings_due.push_back(r);
            failed     = 1'b0;
            failed_idx = '0;
            crc        = init;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        task compare(string name, longint got, longint want);
            if (got != want) begin
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
            end
        endtask

        task check_reading(reading_t got);
            reading_t want;
            if (readings_due.size() == 0) begin
                report("reading arrived with no completed frame behind it");
                return;
            end
            want = readings_due.pop_front();
            compare("co2_ticks", got.co2, want.co2);
            compare("temperature_milli_c", got.temp, want.temp);
            compare("humidity_milli_pct", got.hum, want.hum);
            compare("status", got.status, want.status);
            compare("failing_word", got.failing, want.failing);
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [BYTE_W-1:0]     cfg_data  = '0;

    reading_scoreboard board;
    frame_byte_t       outgoing_q[$];
    int                idle_pct    = BUSY_PCT;
    int                bytes_sent  = 0;
    int                cycle_count = 0;

    gas_sensor_frame_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // End the run as failed if it is still going when the watchdog limit is reached.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Stall the result side at random; idle_pct drops to zero in the quiet phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // Unpack each accepted result word and hand it to the scoreboard.
    always @(posedge aclk) begin
        reading_t seen;
        if (aresetn && m_tvalid && m_tready) begin
            seen.co2     = m_tdata[15:0];
            seen.temp    = m_tdata[33:16];
            seen.hum     = m_tdata[50:34];
            seen.status  = m_tuser[0];
            seen.failing = m_tuser[2:1];
            board.check_reading(seen);
        end
    end

    // Mostly random sensor words, with the extremes mixed in.
    function automatic logic [WORD_W-1:0] sensor_word();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return '1;
        end
        return WORD_W'($urandom_range(65535));
    endfunction

    // Append one well-formed frame, check bytes computed with the current settings.
    function automatic void queue_frame(logic flagged, logic [WORD_W-1:0] co2,
                                        logic [WORD_W-1:0] temp, logic [WORD_W-1:0] hum);
        logic [WORD_W-1:0] w[3];
        logic [BYTE_W-1:0] c;
        w[0] = co2;
        w[1] = temp;
        w[2] = hum;
        for (int i = 0; i < 3; i++) begin
            c = board.crc_next(board.init, w[i][15:8]);
            c = board.crc_next(c, w[i][7:0]);
            outgoing_q.push_back('{start: (i == 0) ? flagged : 1'b0, value: w[i][15:8]});
            outgoing_q.push_back('{start: 1'b0, value: w[i][7:0]});
            outgoing_q.push_back('{start: 1'b0, value: c});
        end
    endfunction

    // Send n queued bytes, one word per handshake, with random gaps in front.
    task automatic send_queued(int n);
        frame_byte_t fb;
        repeat (n) begin
            fb = outgoing_q.pop_front();
            while ($urandom_range(99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= fb.value;
            s_tuser  <= fb.start;
            @(posedge aclk);
            while (!s_tready) begin
                @(posedge aclk);
            end
            board.take_byte(fb.value, fb.start);
            bytes_sent++;
        end
    endtask

    // Leave cfg_valid high across back-to-back writes; the caller drops it.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        board.load_reg(idx, val);
    endtask

    // Hold the byte side, let every owed reading out, then give the pipe time to empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.readings_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int                base;
        int                idx;
        logic [BYTE_W-1:0] poly_val;
        logic [BYTE_W-1:0] init_val;

        board = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: first frame right after reset with no start flag, all-zero words.
        queue_frame(1'b0, '0, '0, '0);
        // Full-scale words, again unflagged, right after a completed frame.
        queue_frame(1'b0, '1, '1, '1);
        // Flagged frame cut after four bytes, then a flagged frame resyncs.
        queue_frame(1'b1, 16'h1234, 16'h5678, 16'h9ABC);
        repeat (5) void'(outgoing_q.pop_back());
        // Bad check bytes on the temperature and humidity words: report the first only.
        queue_frame(1'b1, 16'h8000, 16'h6666, 16'h3333);
        idx = outgoing_q.size() - 4;
        outgoing_q[idx].value = outgoing_q[idx].value ^ 8'h01;
        idx = outgoing_q.size() - 1;
        outgoing_q[idx].value = outgoing_q[idx].value ^ 8'h80;
        send_queued(outgoing_q.size());

        for (int p = 0; p < PHASES; p++) begin
            settle();
            idle_pct = (p == QUIET_PHASE) ? 0 : BUSY_PCT;
            case (p)
                0: begin poly_val = CRC_POLY_RESET; init_val = CRC_INIT_RESET; end
                1: begin poly_val = 8'h00; init_val = 8'h00; end
                2: begin poly_val = 8'hFF; init_val = 8'h00; end
                3: begin poly_val = 8'h07; init_val = 8'hFF; end
                default: begin
                    poly_val = 8'($urandom_range(255));
                    init_val = 8'($urandom_range(255));
                end
            endcase
            // Writes to indexes past the register list must leave both registers alone.
            if (p == 0) begin
                write_reg(REG_SPARE_2, 8'($urandom_range(255)));
                write_reg(REG_SPARE_3, 8'($urandom_range(255)));
            end else if ($urandom_range(2) == 0) begin
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                          8'($urandom_range(255)));
            end
            write_reg(REG_CRC_POLY, poly_val);
            write_reg(REG_CRC_INIT, init_val);
            cfg_valid <= 1'b0;

            // Finish a frame split across the register write, if one is pending.
            base = bytes_sent;
            send_queued(outgoing_q.size());

            while (bytes_sent - base < BYTES_PER_PHASE) begin
                if ($urandom_range(99) < 80) begin
                    queue_frame($urandom_range(99) < 85, sensor_word(), sensor_word(),
                                sensor_word());
                    if ($urandom_range(99) < 30) begin
                        idx = outgoing_q.size() - 1 - $urandom_range(8);
                        outgoing_q[idx].value = outgoing_q[idx].value ^
                                                8'($urandom_range(1, 255));
                    end
                    if ($urandom_range(99) < 5) begin
                        idx = outgoing_q.size() - 1 - $urandom_range(7);
                        outgoing_q[idx].start = 1'b1;
                    end
                end else begin
                    // Noise: a short run of random bytes with stray start flags.
                    repeat ($urandom_range(1, 12)) begin
                        outgoing_q.push_back('{start: ($urandom_range(3) == 0),
                                               value: 8'($urandom_range(255))});
                    end
                end
                send_queued(outgoing_q.size());
            end

            // Stop partway into a frame so the next settings land mid-frame.
            if (p < PHASES - 1 && (p == 0 || $urandom_range(1) == 1)) begin
                queue_frame($urandom_range(1), sensor_word(), sensor_word(), sensor_word());
                send_queued((p == 0) ? 4 : $urandom_range(1, 8));
            end
        end

        s_tvalid <= 1'b0;
        while (board.readings_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.readings_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/gsfd_pkg.sv
design/gsfd_core.sv
design/gsfd_scale.sv
design/gas_sensor_frame_decoder_top.sv
dv/gas_sensor_frame_decoder_top_test.sv
